### rtl/core/sss_pkg.sv
package sss_pkg;

  localparam int MARK_IN_W = 7;
  localparam int FIELD_W   = 6;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABSENT  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_SCAN,
    ST_SUM,
    ST_RD,
    ST_EV
  } sss_state_t;

  typedef struct packed {
    logic ready;
    logic done;
  } sss_hist_sts_t;

endpackage

### rtl/core/sss_hist.sv
module sss_hist #(
  parameter int MAX_STUDENTS = 32,
  parameter int MARK_BINS    = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                inc_vld,
  input  logic [$clog2(MARK_BINS)-1:0]        inc_bin,
  input  logic                                scan_start,
  output sss_pkg::sss_hist_sts_t              sts,
  output logic [$clog2(MARK_BINS)-1:0]        mode_bin,
  output logic [$clog2(MAX_STUDENTS+1)-1:0]   mode_cnt
);
  import sss_pkg::*;

  localparam int BinW = $clog2(MARK_BINS);
  localparam int CntW = $clog2(MAX_STUDENTS + 1);
  localparam logic [BinW-1:0] LastBin = BinW'(MARK_BINS - 1);

  logic [CntW-1:0] mem [MARK_BINS];

  logic            init_r;
  logic            scan_act_r;
  logic [BinW-1:0] sweep_r;
  logic [CntW-1:0] rd_q_r;
  logic            s1_vld_r;
  logic [BinW-1:0] s1_addr_r;
  logic            wb_vld_r;
  logic [BinW-1:0] wb_addr_r;
  logic [CntW-1:0] wb_data_r;
  logic            sv_vld_r;
  logic [BinW-1:0] sv_addr_r;
  logic [CntW-1:0] best_cnt_r;
  logic [BinW-1:0] best_bin_r;
  logic            done_r;

  logic            rd_en;
  logic [BinW-1:0] rd_addr;
  logic [CntW-1:0] base;
  logic [CntW-1:0] inc_data;

  assign rd_en    = inc_vld | scan_act_r;
  assign rd_addr  = scan_act_r ? sweep_r : inc_bin;
  // forward the previous beat's write when it hit the same bin
  assign base     = (wb_vld_r && (wb_addr_r == s1_addr_r)) ? wb_data_r : rd_q_r;
  assign inc_data = base + CntW'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
    if (s1_vld_r) begin
      mem[s1_addr_r] <= inc_data;
    end else if (sv_vld_r) begin
      mem[sv_addr_r] <= '0;
    end else if (init_r) begin
      mem[sweep_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b1;
      sweep_r    <= '0;
      scan_act_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      wb_vld_r   <= 1'b0;
      sv_vld_r   <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_vld_r <= inc_vld;
      wb_vld_r <= s1_vld_r;
      sv_vld_r <= scan_act_r;
      if (init_r) begin
        sweep_r <= sweep_r + BinW'(1);
        if (sweep_r == LastBin) begin
          init_r <= 1'b0;
        end
      end else if (scan_start) begin
        scan_act_r <= 1'b1;
        sweep_r    <= '0;
        done_r     <= 1'b0;
      end else if (scan_act_r) begin
        sweep_r <= sweep_r + BinW'(1);
        if (sweep_r == LastBin) begin
          scan_act_r <= 1'b0;
        end
      end
      if (sv_vld_r && (sv_addr_r == LastBin)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= inc_bin;
    wb_addr_r <= s1_addr_r;
    wb_data_r <= inc_data;
    sv_addr_r <= sweep_r;
    if (scan_start) begin
      best_cnt_r <= '0;
      best_bin_r <= '0;
    end else if (sv_vld_r && (rd_q_r >= best_cnt_r)) begin
      // later (higher) bin wins a tie
      best_cnt_r <= rd_q_r;
      best_bin_r <= sv_addr_r;
    end
  end

  assign sts.ready = ~init_r;
  assign sts.done  = done_r;
  assign mode_bin  = best_bin_r;
  assign mode_cnt  = best_cnt_r;

endmodule

### rtl/core/sss_div.sv
module sss_div #(
  parameter int MAX_STUDENTS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [$clog2(63*MAX_STUDENTS+1)-1:0]    dividend,
  input  logic [$clog2(MAX_STUDENTS+1)-1:0]       divisor,
  output logic                                    done,
  output logic [$clog2(63*MAX_STUDENTS+1)-1:0]    quotient
);
  import sss_pkg::*;

  localparam int SumW  = $clog2(63 * MAX_STUDENTS + 1);
  localparam int CntW  = $clog2(MAX_STUDENTS + 1);
  localparam int StepW = $clog2(SumW + 1);

  logic             busy_r;
  logic             done_r;
  logic [StepW-1:0] step_r;
  logic [CntW-1:0]  rem_r;
  logic [CntW-1:0]  dvs_r;
  logic [SumW-1:0]  quo_r;

  logic [CntW:0]    trial;
  logic [CntW:0]    diff;
  logic             ge;

  // one restoring step per cycle, dividend shifts out MSB first
  assign trial = {rem_r, quo_r[SumW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= StepW'(SumW);
    end else if (busy_r) begin
      step_r <= step_r - StepW'(1);
      if (step_r == StepW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
      quo_r <= {quo_r[SumW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/score_set_statistics_unit.sv
// Score set statistics.
// Input channel (in_valid/in_ready): one beat per student, in roll order, carrying
// the mark (-1 or any negative value means absent) and last, which closes the set.
// Marks load at one beat per cycle; each present mark updates a histogram memory
// through a read-modify-write with forwarding, plus sum, counts and min/max trackers.
// After the closing beat in_ready drops. A drain state follows, then a sweep over
// the MARK_BINS histogram bins (one memory read per cycle) that finds the mode and
// zeroes each bin; the average divider runs alongside it.
// Result channel (out_valid/out_ready): the summary beat comes first, then one beat
// per student holding the mode mark, then one per absent student, each found by
// reading the mark store roll by roll (one pass for each kind). out_final_res
// flags the last beat of the set; in_ready rises again once it has been loaded.
// From the closing beat to the summary come the drain, the sweep, seeing the sweep
// done and the summary load, while the sweep outlasts the divider.
// A result register sits on the output; a stalled receiver holds the current beat
// and pauses the roll sweep, nothing is dropped.
// After reset the histogram is cleared by a sweep over the MARK_BINS bins with
// in_ready low; the mark store needs no clearing.
module score_set_statistics_unit #(
  parameter int MAX_STUDENTS = 32,
  parameter int MARK_BINS    = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sss_pkg::MARK_IN_W-1:0]   in_mark,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sss_pkg::KIND_W-1:0]             out_kind,
  output logic [sss_pkg::FIELD_W-1:0]            out_average,
  output logic [sss_pkg::FIELD_W-1:0]            out_highest,
  output logic [sss_pkg::FIELD_W-1:0]            out_highest_roll,
  output logic [sss_pkg::FIELD_W-1:0]            out_lowest,
  output logic [sss_pkg::FIELD_W-1:0]            out_lowest_roll,
  output logic [sss_pkg::FIELD_W-1:0]            out_mode_mark,
  output logic [sss_pkg::FIELD_W-1:0]            out_mode_count,
  output logic [sss_pkg::FIELD_W-1:0]            out_absent_count,
  output logic [sss_pkg::FIELD_W-1:0]            out_roll,
  output logic                                   out_none_present,
  output logic                                   out_final_res
);
  import sss_pkg::*;

  localparam int BinW    = $clog2(MARK_BINS);
  localparam int CntW    = $clog2(MAX_STUDENTS + 1);
  localparam int SumW    = $clog2(63 * MAX_STUDENTS + 1);
  localparam int IdxW    = (MAX_STUDENTS > 1) ? $clog2(MAX_STUDENTS) : 1;
  localparam int RemW    = CntW + 1;
  localparam int CmpW    = (BinW > FIELD_W) ? BinW : FIELD_W;
  localparam int MarkTop = (MARK_BINS - 1 < 63) ? (MARK_BINS - 1) : 63;

  sss_state_t state_r, state_nxt;

  logic [CntW-1:0]    stu_cnt_r;
  logic [CntW-1:0]    pres_cnt_r;
  logic [SumW-1:0]    sum_r;
  logic               max_vld_r, min_vld_r;
  logic [FIELD_W-1:0] max_mark_r, min_mark_r;
  logic [CntW-1:0]    max_roll_r, min_roll_r;
  logic [IdxW-1:0]    roll_i_r;
  logic               pass_r;
  logic [RemW-1:0]    rem_r;

  logic [FIELD_W:0]   ms_mem [MAX_STUDENTS];
  logic [FIELD_W:0]   ms_q_r;

  logic                   out_valid_r;
  logic [KIND_W-1:0]      out_kind_r;
  logic [FIELD_W-1:0]     out_average_r, out_highest_r, out_highest_roll_r;
  logic [FIELD_W-1:0]     out_lowest_r, out_lowest_roll_r, out_mode_mark_r;
  logic [FIELD_W-1:0]     out_mode_count_r, out_absent_count_r, out_roll_r;
  logic                   out_none_present_r, out_final_res_r;

  logic               in_fire;
  logic               rec;
  logic               neg;
  logic [FIELD_W-1:0] raw6;
  logic [FIELD_W-1:0] m_sat;
  logic [CntW-1:0]    roll_new;
  logic [CntW-1:0]    absent;
  logic [RemW-1:0]    total;
  logic [RemW-1:0]    rem_now;
  logic [CntW-1:0]    roll_num;
  logic               is_last_roll;
  logic               hit;
  logic               slot_free;

  logic               scan_start;
  logic               div_start;
  logic               rd_en;
  logic               out_load;
  logic               out_final;
  logic               advance;
  logic               set_clr;

  sss_hist_sts_t      hist_sts;
  logic [BinW-1:0]    mode_bin;
  logic [CntW-1:0]    mode_cnt;
  logic               div_done;
  logic [SumW-1:0]    div_q;

  sss_hist #(
    .MAX_STUDENTS (MAX_STUDENTS),
    .MARK_BINS    (MARK_BINS)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .inc_vld    (rec && !neg),
    .inc_bin    (BinW'(m_sat)),
    .scan_start (scan_start),
    .sts        (hist_sts),
    .mode_bin   (mode_bin),
    .mode_cnt   (mode_cnt)
  );

  sss_div #(
    .MAX_STUDENTS (MAX_STUDENTS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (pres_cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_fire   = in_valid && in_ready;
  assign rec       = in_fire && (stu_cnt_r < CntW'(MAX_STUDENTS));
  assign neg       = in_mark[MARK_IN_W-1];
  assign raw6      = in_mark[FIELD_W-1:0];
  assign m_sat     = (raw6 > FIELD_W'(MarkTop)) ? FIELD_W'(MarkTop) : raw6;
  assign roll_new  = stu_cnt_r + CntW'(1);
  assign absent    = stu_cnt_r - pres_cnt_r;
  assign total     = RemW'(1) + ((pres_cnt_r != '0) ? RemW'(mode_cnt) : RemW'(0))
                     + RemW'(absent);
  assign rem_now   = (state_r == ST_SUM) ? total : rem_r;
  assign roll_num  = CntW'(roll_i_r) + CntW'(1);
  assign is_last_roll = (roll_num == stu_cnt_r);
  assign slot_free = !out_valid_r || out_ready;
  assign hit       = pass_r ? ms_q_r[FIELD_W]
                            : (!ms_q_r[FIELD_W] &&
                               (CmpW'(ms_q_r[FIELD_W-1:0]) == CmpW'(mode_bin)));

  // FSM outputs
  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    advance    = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_ready = hist_sts.ready;
      ST_DRAIN: begin
        scan_start = 1'b1;
        div_start  = 1'b1;
      end
      ST_SCAN:  ;
      ST_SUM:   out_load = slot_free;
      ST_RD:    rd_en = 1'b1;
      ST_EV: begin
        out_load = hit && slot_free;
        advance  = !hit || slot_free;
      end
      default:  ;
    endcase
  end

  assign out_final = (rem_now == RemW'(1));

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (hist_sts.done && div_done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_load) begin
          state_nxt = out_final ? ST_LOAD : ST_RD;
        end
      end
      ST_RD: state_nxt = ST_EV;
      ST_EV: begin
        if (out_load && out_final) begin
          state_nxt = ST_LOAD;
        end else if (advance) begin
          state_nxt = (is_last_roll && pass_r) ? ST_LOAD : ST_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign set_clr = (state_r != ST_LOAD) && (state_nxt == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-set accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || set_clr) begin
      stu_cnt_r  <= '0;
      pres_cnt_r <= '0;
      sum_r      <= '0;
      max_vld_r  <= 1'b0;
      min_vld_r  <= 1'b0;
      max_mark_r <= '0;
      min_mark_r <= '0;
      max_roll_r <= '0;
      min_roll_r <= '0;
    end else if (rec) begin
      stu_cnt_r <= roll_new;
      if (!neg) begin
        pres_cnt_r <= pres_cnt_r + CntW'(1);
        sum_r      <= sum_r + SumW'(m_sat);
        if (!max_vld_r || (m_sat >= max_mark_r)) begin
          max_vld_r  <= 1'b1;
          max_mark_r <= m_sat;
          max_roll_r <= roll_new;
        end
        if (!min_vld_r || (m_sat <= min_mark_r)) begin
          min_vld_r  <= 1'b1;
          min_mark_r <= m_sat;
          min_roll_r <= roll_new;
        end
      end
    end
  end

  // mark store: absent flag over saturated mark
  always_ff @(posedge clk) begin
    if (rec) begin
      ms_mem[stu_cnt_r[IdxW-1:0]] <= {neg, m_sat};
    end
    if (rd_en) begin
      ms_q_r <= ms_mem[roll_i_r];
    end
  end

  // roll sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_i_r <= '0;
      pass_r   <= 1'b0;
      rem_r    <= '0;
    end else begin
      if (out_load) begin
        rem_r <= rem_now - RemW'(1);
      end
      if ((state_r == ST_SUM) && out_load) begin
        roll_i_r <= '0;
        pass_r   <= (pres_cnt_r == '0);
      end else if (advance && !(out_load && out_final)) begin
        if (is_last_roll) begin
          roll_i_r <= '0;
          pass_r   <= 1'b1;
        end else begin
          roll_i_r <= roll_i_r + IdxW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_final_res_r <= out_final;
      if (state_r == ST_SUM) begin
        out_kind_r         <= KIND_SUMMARY;
        out_absent_count_r <= FIELD_W'(absent);
        out_roll_r         <= '0;
        out_none_present_r <= (pres_cnt_r == '0);
        if (pres_cnt_r != '0) begin
          out_average_r      <= div_q[FIELD_W-1:0];
          out_highest_r      <= max_mark_r;
          out_highest_roll_r <= FIELD_W'(max_roll_r);
          out_lowest_r       <= min_mark_r;
          out_lowest_roll_r  <= FIELD_W'(min_roll_r);
          out_mode_mark_r    <= FIELD_W'(mode_bin);
          out_mode_count_r   <= FIELD_W'(mode_cnt);
        end else begin
          out_average_r      <= '0;
          out_highest_r      <= '0;
          out_highest_roll_r <= '0;
          out_lowest_r       <= '0;
          out_lowest_roll_r  <= '0;
          out_mode_mark_r    <= '0;
          out_mode_count_r   <= '0;
        end
      end else begin
        out_kind_r         <= pass_r ? KIND_ABSENT : KIND_MODE;
        out_roll_r         <= FIELD_W'(roll_num);
        out_absent_count_r <= '0;
        out_none_present_r <= 1'b0;
        out_average_r      <= '0;
        out_highest_r      <= '0;
        out_highest_roll_r <= '0;
        out_lowest_r       <= '0;
        out_lowest_roll_r  <= '0;
        out_mode_mark_r    <= '0;
        out_mode_count_r   <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_average      = out_average_r;
  assign out_highest      = out_highest_r;
  assign out_highest_roll = out_highest_roll_r;
  assign out_lowest       = out_lowest_r;
  assign out_lowest_roll  = out_lowest_roll_r;
  assign out_mode_mark    = out_mode_mark_r;
  assign out_mode_count   = out_mode_count_r;
  assign out_absent_count = out_absent_count_r;
  assign out_roll         = out_roll_r;
  assign out_none_present = out_none_present_r;
  assign out_final_res    = out_final_res_r;

  a_counts_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (stu_cnt_r <= CntW'(MAX_STUDENTS)) && (pres_cnt_r <= stu_cnt_r))
    else $error("present count exceeds student count");

  a_final_closes_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_final |=> (state_r == ST_LOAD) && (stu_cnt_r == '0))
    else $error("set not closed after final beat");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_EV) |-> (rem_r != '0))
    else $error("roll sweep running with no results left");

  a_summary_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (hist_sts.done && div_done))
    else $error("summary issued before scan and divide finished");

endmodule
